[design/slirm_pkg.sv]
`timescale 1ns / 1ps

package slirm_pkg;

  // Store size and width of the internal entry count
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Width of the reported count field
  localparam int COUNT_W = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  // Control bundle from the top level to the cell row
  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } ctrl_t;

endpackage

[design/slirm_cell.sv]
`timescale 1ns / 1ps

// One slot of the descending row: slot 0 holds the largest value.
module slirm_cell import slirm_pkg::*; (
  input  logic               clk,
  input  ctrl_t              ctrl,
  input  logic               occ,
  input  logic               left_ge,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  output logic               ge,
  output logic signed [31:0] entry
);

  logic signed [31:0] entry_next;

  // Slot keeps its value on push when it is occupied and not smaller
  assign ge = occ && !(entry < ctrl.value);

  // Push: keep, take the new value, or take the left neighbor's; pop: shift left
  always_comb begin
    unique case (ctrl.op)
      OP_PUSH: begin
        if (ge) begin
          entry_next = entry;
        end else if (left_ge) begin
          entry_next = ctrl.value;
        end else begin
          entry_next = left_entry;
        end
      end
      OP_POP:  entry_next = right_entry;
      OP_HOLD: entry_next = entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[design/sorted_list_insert_remove_max.sv]
`timescale 1ns / 1ps

// Channel  Handshake             Fields
// in       in_valid / in_stall   kind, value
// out      out_valid / out_stall status, count, smallest, largest
//
// Each beat updates the cell row; one beat per cycle is
// accepted while the result register is empty or being taken.
// The result appears in the output register the cycle after acceptance.
// in_stall is high only while a result waits under out_stall.
// Reset (rst, synchronous) empties the store and the output register;
// stored values are not cleared, the count alone marks them valid.
module sorted_list_insert_remove_max import slirm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count,
  output logic signed [31:0] smallest,
  output logic signed [31:0] largest
);

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic signed [31:0] small_r;
  logic signed [31:0] small_next;
  logic signed [31:0] large_next;
  status_t            st_next;
  ctrl_t              ctrl;
  logic               in_accept;

  logic signed [31:0] entry [DEPTH];
  logic               ge    [DEPTH];
  logic               occ   [DEPTH];

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Decode the beat into a row operation and the new summary values
  always_comb begin
    ctrl.value = value;
    ctrl.op    = OP_HOLD;
    cnt_next   = cnt;
    small_next = small_r;
    large_next = entry[0];
    st_next    = ST_DONE;
    if (!kind) begin
      if (cnt == CNT_W'(DEPTH)) begin
        st_next = ST_FULL;
      end else begin
        ctrl.op  = OP_PUSH;
        cnt_next = cnt + 1'b1;
        if (cnt == '0 || value < small_r) begin
          small_next = value;
        end
        if (cnt == '0 || value > entry[0]) begin
          large_next = value;
        end
      end
    end else begin
      if (cnt == '0) begin
        st_next = ST_EMPTY;
      end else begin
        ctrl.op    = OP_POP;
        cnt_next   = cnt - 1'b1;
        large_next = entry[1];
      end
    end
    // Row holds unless a beat is taken this cycle
    if (!in_accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < cnt;
    if (i == 0) begin : g_first
      slirm_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ[i]),
        .left_ge     (1'b1),
        .left_entry  (value),
        .right_entry (entry[i+1]),
        .ge          (ge[i]),
        .entry       (entry[i])
      );
    end else if (i == DEPTH - 1) begin : g_last
      slirm_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ[i]),
        .left_ge     (ge[i-1]),
        .left_entry  (entry[i-1]),
        .right_entry (entry[i]),
        .ge          (ge[i]),
        .entry       (entry[i])
      );
    end else begin : g_mid
      slirm_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ[i]),
        .left_ge     (ge[i-1]),
        .left_entry  (entry[i-1]),
        .right_entry (entry[i+1]),
        .ge          (ge[i]),
        .entry       (entry[i])
      );
    end
  end

  // Count and tracked minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      small_r <= small_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status <= st_next;
      count  <= COUNT_W'(cnt_next);
      if (cnt_next == '0) begin
        smallest <= '0;
        largest  <= '0;
      end else begin
        smallest <= small_next;
        largest  <= large_next;
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !kind && cnt == CNT_W'(DEPTH)) |=>
      (status == ST_FULL && cnt == $past(cnt)))
    else $error("push on full store not rejected");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind && cnt == '0) |=>
      (status == ST_EMPTY && count == '0 && largest == '0))
    else $error("pop on empty store not rejected");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count != '0) |-> (largest >= smallest))
    else $error("largest below smallest");

  a_push_cnt: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !kind && cnt != CNT_W'(DEPTH)) |=> (cnt == $past(cnt) + 1'b1))
    else $error("push did not grow the store");
`endif

endmodule
